### sv/tpnc_pkg.sv
// Shared widths, register codes, reset values and control structs of the tone classifier.
package tpnc_pkg;

  localparam int PERIOD_W = 17;
  localparam int DEB_W    = 16;
  localparam int TOL_W    = 10;
  localparam int FREQ_W   = 14;
  localparam int DRIFT_W  = 15;
  localparam int IDX_OUT_W = 3;
  localparam int CNT_OUT_W = 4;
  localparam int CFG_IDX_W = 8;
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 24;

  localparam int NOTE_COUNT_DEF       = 8;
  localparam int TICKS_PER_SECOND_DEF = 1000000;

  localparam logic [PERIOD_W-1:0] CNT_MAX  = '1;
  localparam logic [FREQ_W-1:0]   FREQ_MAX = '1;

  localparam logic [DEB_W-1:0]    DEBOUNCE_RST = DEB_W'(100);
  localparam logic [PERIOD_W-1:0] TIMEOUT_RST  = PERIOD_W'(100000);
  localparam logic [TOL_W-1:0]    TOLERANCE_RST = TOL_W'(30);
  localparam logic [FREQ_W-1:0]   LIMIT_RST    = FREQ_W'(1500);

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_DEBOUNCE  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_TIMEOUT   = cfg_idx_t'(1);
  localparam cfg_idx_t REG_TOLERANCE = cfg_idx_t'(2);
  localparam cfg_idx_t REG_LIMIT     = cfg_idx_t'(3);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic tick;
    logic div_step;
    logic calib;
    logic scan_clr;
    logic scan_step;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_done;
    logic query;
    logic calib_full;
    logic freq_nz;
    logic hit;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

### sv/tone_period_note_classifier.sv
// Top level of the tone period note classifier: controller plus datapath.
// Usage:
//   in_*  : one item per microsecond tick; in_tdata[0] = edge_req, in_tdata[1] = query.
//   out_* : one result item per input item, in order, held in an output register
//           until out_tready takes it.
//   cfg_* : register writes (0 debounce, 1 timeout, 2 tolerance, 3 calibration limit),
//           always ready, to be issued while the block is idle; other indexes are ignored.
// Sequence: each item passes a tick update, a restoring divide of TICKS_PER_SECOND by the
//   period into DIV_W = clog2(TICKS_PER_SECOND+1) quotient bits (20 at the default rate),
//   one quotient bit per cycle, a decide step, a note scan on a note lookup only, and output.
//   The scan visits one slot per cycle, in order, up to the first match or the last slot.
// Reset: tick counters and configuration registers return to their defaults, no notes are
//   calibrated and all drifts are zero; the block is ready in the first cycle after reset.
// Stall: a finished item waits in the output register; the next input item is taken
//   meanwhile and worked on, and waits before output until the register frees.
module tone_period_note_classifier #(
  parameter int NOTE_COUNT       = tpnc_pkg::NOTE_COUNT_DEF,
  parameter int TICKS_PER_SECOND = tpnc_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tpnc_pkg::IN_DATA_W-1:0]  in_tdata,   // [0] edge_req, [1] query, rest zero
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tpnc_pkg::OUT_DATA_W-1:0] out_tdata,  // [0] period_ok, [14:1] freq_hz,
                                                      // [15] match_found, [18:16] note_index,
                                                      // [22:19] notes_stored, [23] stored_now
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  tpnc_pkg::cfg_idx_t              cfg_index,
  input  logic [tpnc_pkg::PERIOD_W-1:0]   cfg_data
);
  import tpnc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  tpnc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tpnc_datapath #(
    .NOTE_COUNT       (NOTE_COUNT),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .edge_req   (in_tdata[0]),
    .query      (in_tdata[1]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

### sv/tpnc_ctrl.sv
// Controller state machine of the tone classifier: sequences tick, divide, store or scan, output.
module tpnc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  tpnc_pkg::sts_t sts,
  output tpnc_pkg::cmd_t cmd
);
  import tpnc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DIV    = 5'b00010,
    S_DECIDE = 5'b00100,
    S_SCAN   = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Decode commands and next state
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.tick = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_OUT;
        if (sts.query) begin
          if (!sts.calib_full) begin
            cmd.calib = 1'b1;
          end else if (sts.freq_nz) begin
            cmd.scan_clr = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.hit || sts.scan_last) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

### sv/tpnc_datapath.sv
// Datapath of the tone classifier: tick counters, serial divider, note store and output register.
module tpnc_datapath #(
  parameter int NOTE_COUNT       = tpnc_pkg::NOTE_COUNT_DEF,
  parameter int TICKS_PER_SECOND = tpnc_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  tpnc_pkg::cfg_idx_t                 cfg_index,
  input  logic [tpnc_pkg::PERIOD_W-1:0]      cfg_data,
  input  logic                               edge_req,
  input  logic                               query,
  input  logic                               out_tready,
  output logic                               out_tvalid,
  output logic [tpnc_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  tpnc_pkg::cmd_t                     cmd,
  output tpnc_pkg::sts_t                     sts
);
  import tpnc_pkg::*;

  localparam int IDX_W  = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
  localparam int CNT_W  = $clog2(NOTE_COUNT + 1);
  localparam int DIV_W  = $clog2(TICKS_PER_SECOND + 1);
  localparam int DCNT_W = $clog2(DIV_W + 1);
  localparam int QW     = (DIV_W > FREQ_W) ? DIV_W : FREQ_W;
  localparam int DIFF_W = FREQ_W + 3;

  // Configuration registers
  logic [DEB_W-1:0]    debounce_r;
  logic [PERIOD_W-1:0] timeout_r;
  logic [TOL_W-1:0]    tol_r;
  logic [FREQ_W-1:0]   limit_r;

  // Period measurement state
  logic [PERIOD_W-1:0] since_acc_r, since_acc_nxt;
  logic [PERIOD_W-1:0] since_start_r, since_start_nxt;
  logic                first_pend_r, first_pend_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic                period_ok_r, period_ok_nxt;
  logic                query_r;

  // Divider state
  logic [PERIOD_W-1:0] rem_r;
  logic [DIV_W-1:0]    quot_r;
  logic [DIV_W-1:0]    dvd_r;
  logic [DCNT_W-1:0]   dcnt_r;

  // Note store
  logic [FREQ_W-1:0]  note_freq_r  [NOTE_COUNT];
  logic [DRIFT_W-1:0] note_drift_r [NOTE_COUNT];
  logic [CNT_W-1:0]   calib_cnt_r;
  logic [IDX_W-1:0]   scan_idx_r;
  logic               match_r;
  logic               stored_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [PERIOD_W-1:0] sa_inc, ss_inc;
  logic                timed_out, accept_edge;
  logic [PERIOD_W:0]   trial, trial_sub;
  logic                trial_ge;
  logic [QW-1:0]       quot_ext;
  logic [FREQ_W-1:0]   freq_sat, freq_w;
  logic                freq_nz;
  logic signed [DIFF_W-1:0] diff, new_drift;
  logic [DIFF_W-1:0]   diff_abs;
  logic                hit;
  logic                scan_last;
  logic [IDX_W-1:0]    calib_idx;

  // Tick update: saturating counters, timeout, debounced edge
  assign sa_inc = (since_acc_r == CNT_MAX) ? since_acc_r : since_acc_r + 1'b1;
  assign ss_inc = (since_start_r == CNT_MAX) ? since_start_r : since_start_r + 1'b1;
  assign timed_out   = sa_inc > timeout_r;
  assign accept_edge = edge_req && (sa_inc > {1'b0, debounce_r});

  always_comb begin
    period_ok_nxt   = timed_out ? 1'b0 : period_ok_r;
    first_pend_nxt  = timed_out ? 1'b1 : first_pend_r;
    period_nxt      = period_r;
    since_acc_nxt   = sa_inc;
    since_start_nxt = ss_inc;
    if (accept_edge) begin
      if (first_pend_nxt) begin
        first_pend_nxt = 1'b0;
      end else begin
        period_nxt    = ss_inc;
        period_ok_nxt = 1'b1;
      end
      since_acc_nxt   = '0;
      since_start_nxt = '0;
    end
  end

  // Configuration writes and tick state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r    <= DEBOUNCE_RST;
      timeout_r     <= TIMEOUT_RST;
      tol_r         <= TOLERANCE_RST;
      limit_r       <= LIMIT_RST;
      since_acc_r   <= CNT_MAX;
      since_start_r <= '0;
      first_pend_r  <= 1'b1;
      period_r      <= '0;
      period_ok_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_DEBOUNCE:  debounce_r <= cfg_data[DEB_W-1:0];
          REG_TIMEOUT:   timeout_r  <= cfg_data;
          REG_TOLERANCE: tol_r      <= cfg_data[TOL_W-1:0];
          REG_LIMIT:     limit_r    <= cfg_data[FREQ_W-1:0];
          default: ;
        endcase
      end
      if (cmd.tick) begin
        since_acc_r   <= since_acc_nxt;
        since_start_r <= since_start_nxt;
        first_pend_r  <= first_pend_nxt;
        period_r      <= period_nxt;
        period_ok_r   <= period_ok_nxt;
      end
    end
  end

  // Restoring divider: one quotient bit per cycle
  assign trial     = {rem_r, dvd_r[DIV_W-1]};
  assign trial_ge  = trial >= {1'b0, period_r};
  assign trial_sub = trial - {1'b0, period_r};

  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      rem_r  <= '0;
      quot_r <= '0;
      dvd_r  <= DIV_W'(TICKS_PER_SECOND);
      dcnt_r <= DCNT_W'(DIV_W - 1);
    end else if (cmd.div_step) begin
      rem_r  <= trial_ge ? trial_sub[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
      quot_r <= {quot_r[DIV_W-2:0], trial_ge};
      dvd_r  <= {dvd_r[DIV_W-2:0], 1'b0};
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  // Saturate the quotient; zero without a valid period
  assign quot_ext = QW'(quot_r);
  assign freq_sat = (quot_ext > QW'(FREQ_MAX)) ? FREQ_MAX : quot_ext[FREQ_W-1:0];
  assign freq_w   = period_ok_r ? freq_sat : '0;
  assign freq_nz  = (freq_w != '0);

  // Distance of the scanned note from the measured frequency (drift is signed)
  assign diff = $signed({3'b000, note_freq_r[scan_idx_r]})
              + $signed({{(DIFF_W-DRIFT_W){note_drift_r[scan_idx_r][DRIFT_W-1]}},
                         note_drift_r[scan_idx_r]})
              - $signed({3'b000, freq_w});
  assign diff_abs  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign hit       = diff_abs < DIFF_W'(tol_r);
  assign new_drift = $signed({3'b000, freq_w}) - $signed({3'b000, note_freq_r[scan_idx_r]});
  assign scan_last = (scan_idx_r == IDX_W'(NOTE_COUNT - 1));
  assign calib_idx = calib_cnt_r[IDX_W-1:0];

  // Calibration counter, scan index and per-item flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_cnt_r <= '0;
      scan_idx_r  <= '0;
      match_r     <= 1'b0;
      stored_r    <= 1'b0;
      query_r     <= 1'b0;
      for (int i = 0; i < NOTE_COUNT; i++) note_drift_r[i] <= '0;
    end else begin
      if (cmd.tick) begin
        query_r    <= query;
        match_r    <= 1'b0;
        stored_r   <= 1'b0;
        scan_idx_r <= '0;
      end
      if (cmd.calib && freq_nz && (freq_w < limit_r)) begin
        calib_cnt_r <= calib_cnt_r + 1'b1;
        stored_r    <= 1'b1;
      end
      if (cmd.scan_clr) scan_idx_r <= '0;
      if (cmd.scan_step) begin
        if (hit) begin
          note_drift_r[scan_idx_r] <= new_drift[DRIFT_W-1:0];
          match_r <= 1'b1;
        end else if (!scan_last) begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
      end
    end
  end

  // Store a calibrated note
  always_ff @(posedge clk) begin
    if (cmd.calib && freq_nz && (freq_w < limit_r)) note_freq_r[calib_idx] <= freq_w;
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {stored_r,
                     CNT_OUT_W'(calib_cnt_r),
                     match_r ? IDX_OUT_W'(scan_idx_r) : IDX_OUT_W'(0),
                     match_r,
                     freq_w,
                     period_ok_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign sts.div_done   = (dcnt_r == '0);
  assign sts.query      = query_r;
  assign sts.calib_full = (calib_cnt_r == CNT_W'(NOTE_COUNT));
  assign sts.freq_nz    = freq_nz;
  assign sts.hit        = hit;
  assign sts.scan_last  = scan_last;
  assign sts.out_free   = !out_valid_r || out_tready;

endmodule
